>>> rtl/core/assert_macros.svh
// Assertion macros shared by the lattice engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SLPE_ASSERT(lbl, clk, rstn, pexpr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) pexpr) else $error(msg);
`define SLPE_ASSERT_ALWAYS(lbl, clk, pexpr, msg) \
    lbl: assert property (@(posedge clk) pexpr) else $error(msg);
`else
`define SLPE_ASSERT(lbl, clk, rstn, pexpr, msg)
`define SLPE_ASSERT_ALWAYS(lbl, clk, pexpr, msg)
`endif
`endif

>>> rtl/core/slpe_pkg.sv
// Shared types, codes and defaults of the lattice epidemic engine.
package slpe_pkg;
    localparam int SIDE_DEF      = 64;
    localparam int DRAW_BITS_DEF = 16;

    localparam int OP_W       = 2;
    localparam int COORD_IN_W = 6;
    localparam int DIR_W      = 2;
    localparam int DRAW_W     = 16;
    localparam int THR_W      = 16;
    localparam int CNT_OUT_W  = 13;

    localparam logic [THR_W-1:0] THR_RESET = 16'd6554;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_EVENT = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

    typedef logic [1:0] t_site;
    localparam t_site SITE_SUS = 2'd1;
    localparam t_site SITE_INF = 2'd2;
    localparam t_site SITE_REC = 2'd3;
endpackage

>>> rtl/core/slpe_lattice_ram.sv
// Site state memory and visited map, one shared address, registered reads.
module slpe_lattice_ram #(
    parameter int AW = 12
) (
    input  logic            i_clk,
    input  logic [AW-1:0]   i_addr,
    input  logic            i_site_we,
    input  slpe_pkg::t_site i_site_wdata,
    output slpe_pkg::t_site o_site_rdata,
    input  logic            i_vis_we,
    input  logic            i_vis_wdata,
    output logic            o_vis_rdata
);
    import slpe_pkg::*;

    localparam int DEPTH = 1 << AW;

    t_site r_site_mem [DEPTH];
    logic  r_vis_mem  [DEPTH];
    t_site r_site_rd;
    logic  r_vis_rd;

    always_ff @(posedge i_clk) begin
        if (i_site_we) begin
            r_site_mem[i_addr] <= i_site_wdata;
        end
        r_site_rd <= r_site_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_vis_we) begin
            r_vis_mem[i_addr] <= i_vis_wdata;
        end
        r_vis_rd <= r_vis_mem[i_addr];
    end

    assign o_site_rdata = r_site_rd;
    assign o_vis_rdata  = r_vis_rd;
endmodule

>>> rtl/core/sir_lattice_percolation_engine_unit.sv
// Every request ends with its result in the result register; init rewrites the whole lattice
// with one site memory write per cycle.
// A check clears the visited map, reads each top-row site, pops each pushed site and reads
// each of its in-lattice neighbours, then finishes.
// One request at a time; the next is taken the cycle after the result register
// takes the result. Reset runs the init sweep before the first request is taken.
`include "assert_macros.svh"
module sir_lattice_percolation_engine_unit #(
    parameter int SIDE      = slpe_pkg::SIDE_DEF,
    parameter int DRAW_BITS = slpe_pkg::DRAW_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [slpe_pkg::THR_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [slpe_pkg::OP_W-1:0]         i_op,
    input  logic [slpe_pkg::COORD_IN_W-1:0]   i_row,
    input  logic [slpe_pkg::COORD_IN_W-1:0]   i_col,
    input  logic [slpe_pkg::DIR_W-1:0]        i_direction,
    input  logic [slpe_pkg::DRAW_W-1:0]       i_draw,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [slpe_pkg::CNT_OUT_W-1:0]    o_infected_count,
    output logic                              o_extinct,
    output logic                              o_rejected,
    output logic                              o_percolates
);
    import slpe_pkg::*;

    localparam int CW    = $clog2(SIDE);
    localparam int AW    = 2 * CW;
    localparam int SPW   = AW + 1;
    localparam int CNT_W = $clog2(SIDE * SIDE + 1);
    localparam logic [CW-1:0] LAST  = CW'(SIDE - 1);
    localparam logic [CW-1:0] MID   = CW'(SIDE / 2);
    localparam logic [AW-1:0] CENTRE = {MID, MID};
    localparam logic [DRAW_W-1:0] DMASK =
        (DRAW_BITS >= DRAW_W) ? {DRAW_W{1'b1}} : DRAW_W'((64'd1 << DRAW_BITS) - 64'd1);

    localparam logic [3:0] S_SWEEP   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_EV_A    = 4'd2;
    localparam logic [3:0] S_EV_B    = 4'd3;
    localparam logic [3:0] S_EV_C    = 4'd4;
    localparam logic [3:0] S_CK_CLR  = 4'd5;
    localparam logic [3:0] S_SEED_RD = 4'd6;
    localparam logic [3:0] S_SEED_WR = 4'd7;
    localparam logic [3:0] S_POP     = 4'd8;
    localparam logic [3:0] S_POPW    = 4'd9;
    localparam logic [3:0] S_NB_RD   = 4'd10;
    localparam logic [3:0] S_NB_WR   = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;

    logic [3:0]       r_state;
    logic             r_boot;
    logic [THR_W-1:0] r_thr;
    logic [AW-1:0]    r_cnt;
    logic [CNT_W-1:0] r_inf;
    logic [SPW-1:0]   r_sp;
    logic             r_hit;
    logic             r_rej;
    logic             r_perc;
    logic [OP_W-1:0]  r_op;
    logic [CW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic [DIR_W-1:0] r_dir;
    logic [DRAW_W-1:0] r_draw;
    logic             r_coord_ok;
    t_site            r_act_st;
    logic [AW-1:0]    r_cur;
    logic [AW-1:0]    r_cand;
    logic [DIR_W-1:0] r_k;

    logic                  r_out_valid;
    logic [CNT_OUT_W-1:0]  r_out_cnt;
    logic                  r_out_ext;
    logic                  r_out_rej;
    logic                  r_out_perc;

    logic [AW-1:0] r_stack [1 << AW];
    logic [AW-1:0] r_stk_rd;

    logic          accept;
    logic          out_load;
    logic [AW-1:0] mem_addr;
    logic          site_we;
    t_site         site_wdata;
    t_site         site_rd;
    logic          vis_we;
    logic          vis_wdata;
    logic          vis_rd;
    logic          push;
    logic          infect;
    logic          recover;

    logic             chk;
    logic [CW-1:0]    src_row;
    logic [CW-1:0]    src_col;
    logic [DIR_W-1:0] src_dir;
    logic             nb_ok;
    logic [CW-1:0]    nb_row;
    logic [CW-1:0]    nb_col;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // Neighbour generator, shared by the event path and the flood fill.
    assign chk     = (r_state == S_NB_RD);
    assign src_row = chk ? r_cur[AW-1:CW] : r_row;
    assign src_col = chk ? r_cur[CW-1:0]  : r_col;
    assign src_dir = chk ? r_k : r_dir;

    always_comb begin
        nb_row = src_row;
        nb_col = src_col;
        nb_ok  = 1'b1;
        case (src_dir)
            DIR_LEFT: begin
                nb_ok  = (src_col != '0);
                nb_col = src_col - 1'b1;
            end
            DIR_RIGHT: begin
                nb_ok  = (src_col != LAST);
                nb_col = src_col + 1'b1;
            end
            DIR_UP: begin
                nb_ok  = (src_row != '0);
                nb_row = src_row - 1'b1;
            end
            default: begin
                nb_ok  = (src_row != LAST);
                nb_row = src_row + 1'b1;
            end
        endcase
    end

    assign infect  = (r_draw > r_thr) && (r_act_st == SITE_INF) && (site_rd == SITE_SUS);
    assign recover = !(r_draw > r_thr) && (r_act_st == SITE_INF);
    assign push    = ((r_state == S_SEED_WR) || (r_state == S_NB_WR))
                     && (site_rd == SITE_REC) && !vis_rd;

    always_comb begin
        mem_addr   = {r_row, r_col};
        site_we    = 1'b0;
        site_wdata = SITE_SUS;
        vis_we     = 1'b0;
        vis_wdata  = 1'b0;
        case (r_state)
            S_SWEEP: begin
                mem_addr   = r_cnt;
                site_we    = 1'b1;
                site_wdata = (r_cnt == CENTRE) ? SITE_INF : SITE_SUS;
            end
            S_EV_B: begin
                mem_addr = {nb_row, nb_col};
            end
            S_EV_C: begin
                if (infect) begin
                    mem_addr   = {nb_row, nb_col};
                    site_we    = 1'b1;
                    site_wdata = SITE_INF;
                end else begin
                    site_we    = recover;
                    site_wdata = SITE_REC;
                end
            end
            S_CK_CLR: begin
                mem_addr = r_cnt;
                vis_we   = 1'b1;
            end
            S_SEED_RD: begin
                mem_addr = {{CW{1'b0}}, r_cnt[CW-1:0]};
            end
            S_NB_RD: begin
                mem_addr = {nb_row, nb_col};
            end
            S_SEED_WR, S_NB_WR: begin
                mem_addr  = r_cand;
                vis_we    = push;
                vis_wdata = 1'b1;
            end
            default: begin
                mem_addr = {r_row, r_col};
            end
        endcase
    end

    slpe_lattice_ram #(
        .AW(AW)
    ) u_ram (
        .i_clk        (i_clk),
        .i_addr       (mem_addr),
        .i_site_we    (site_we),
        .i_site_wdata (site_wdata),
        .o_site_rdata (site_rd),
        .i_vis_we     (vis_we),
        .i_vis_wdata  (vis_wdata),
        .o_vis_rdata  (vis_rd)
    );

    // Fill stack: push at the depth, pop reads one below it.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[r_sp[AW-1:0]] <= r_cand;
        end
        r_stk_rd <= r_stack[AW'(r_sp - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_boot  <= 1'b1;
            r_cnt   <= '0;
            r_inf   <= CNT_W'(1);
            r_sp    <= '0;
            r_hit   <= 1'b0;
            r_rej   <= 1'b0;
            r_perc  <= 1'b0;
            r_k     <= '0;
        end else begin
            if (push) begin
                r_sp <= r_sp + 1'b1;
            end
            case (r_state)
                S_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == {AW{1'b1}}) begin
                        r_inf   <= CNT_W'(1);
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_FIN;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_rej  <= 1'b0;
                        r_perc <= 1'b0;
                        r_cnt  <= '0;
                        case (i_op)
                            OP_INIT:  r_state <= S_SWEEP;
                            OP_EVENT: r_state <= S_EV_A;
                            OP_CHECK: r_state <= S_CK_CLR;
                            default:  r_state <= S_FIN;
                        endcase
                    end
                end
                S_EV_A: begin
                    if (!r_coord_ok || !nb_ok) begin
                        r_rej   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_EV_B;
                    end
                end
                S_EV_B: begin
                    r_state <= S_EV_C;
                end
                S_EV_C: begin
                    if (infect) begin
                        r_inf <= r_inf + 1'b1;
                    end else if (recover && (r_inf != '0)) begin
                        r_inf <= r_inf - 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_CK_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == {AW{1'b1}}) begin
                        r_sp    <= '0;
                        r_hit   <= 1'b0;
                        r_state <= S_SEED_RD;
                    end
                end
                S_SEED_RD: begin
                    r_cand  <= {{CW{1'b0}}, r_cnt[CW-1:0]};
                    r_state <= S_SEED_WR;
                end
                S_SEED_WR: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= (r_cnt[CW-1:0] == LAST) ? S_POP : S_SEED_RD;
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_perc  <= r_hit;
                        r_state <= S_FIN;
                    end else begin
                        r_sp    <= r_sp - 1'b1;
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    r_cur <= r_stk_rd;
                    if (r_stk_rd[AW-1:CW] == LAST) begin
                        r_hit <= 1'b1;
                    end
                    r_k     <= '0;
                    r_state <= S_NB_RD;
                end
                S_NB_RD: begin
                    r_cand <= {nb_row, nb_col};
                    if (nb_ok) begin
                        r_state <= S_NB_WR;
                    end else if (r_k == DIR_DOWN) begin
                        r_state <= S_POP;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_NB_WR: begin
                    if (r_k == DIR_DOWN) begin
                        r_state <= S_POP;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_NB_RD;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request fields, captured at acceptance, and the state of the acting site, captured during an event.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_op;
            r_row      <= CW'(i_row);
            r_col      <= CW'(i_col);
            r_dir      <= i_direction;
            r_draw     <= i_draw & DMASK;
            r_coord_ok <= (32'(i_row) < 32'(SIDE)) && (32'(i_col) < 32'(SIDE));
        end
        if (r_state == S_EV_B) begin
            r_act_st <= site_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_cnt  <= CNT_OUT_W'(r_inf);
            r_out_ext  <= (r_inf == '0);
            r_out_rej  <= r_rej;
            r_out_perc <= r_perc;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_infected_count = r_out_cnt;
    assign o_extinct        = r_out_ext;
    assign o_rejected       = r_out_rej;
    assign o_percolates     = r_out_perc;

    `SLPE_ASSERT(a_busy_stalls, i_clk, i_rst_n, (r_state != S_IDLE) |-> o_in_stall, "busy but not stalling")
    `SLPE_ASSERT(a_count_range, i_clk, i_rst_n, 32'(r_inf) <= SIDE * SIDE, "infected count out of range")
    `SLPE_ASSERT(a_pop_empty, i_clk, i_rst_n, (r_state == S_POP && r_sp == '0) |=> (r_state == S_FIN), "empty stack did not end check")
    `SLPE_ASSERT(a_flags_excl, i_clk, i_rst_n, o_out_valid |-> !(o_rejected && o_percolates), "rejected and percolates both set")
    `SLPE_ASSERT(a_op_rej, i_clk, i_rst_n, (r_state == S_FIN && r_rej) |-> (r_op == OP_EVENT), "rejection outside an event")
endmodule

>>> tb/sv/tb.sv
// Testbench for the SIR lattice epidemic engine with spanning-cluster check.
`timescale 1ns / 1ps

module tb;
    import slpe_pkg::*;

    localparam int SIDE      = 64;
    localparam int CELLS     = SIDE * SIDE;
    localparam int CENTRE    = (SIDE / 2) * SIDE + SIDE / 2;
    localparam int LIMIT     = 20000000;
    localparam int N_RANDOM  = 720;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] count;
        logic                 extinct;
        logic                 rejected;
        logic                 percolates;
    } t_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [THR_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_op;
    logic [COORD_IN_W-1:0] i_row;
    logic [COORD_IN_W-1:0] i_col;
    logic [DIR_W-1:0]      i_direction;
    logic [DRAW_W-1:0]     i_draw;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CNT_OUT_W-1:0]  o_infected_count;
    logic                  o_extinct;
    logic                  o_rejected;
    logic                  o_percolates;

    // Shadow copy of the lattice and its bookkeeping.
    t_site        lattice [CELLS];
    bit           seen [CELLS];
    int           fill [CELLS];
    int           live_count;
    logic [THR_W-1:0] threshold;

    t_outcome     pending_outcomes [$];
    int           cycles = 0;
    int           mismatches = 0;
    int           items_sent;
    int           checks_sent;
    int           spans_seen = 0;
    int           hold_left = 0;
    int           hold_asked = 0;
    int           hold_served = 0;
    bit           no_gaps;
    bit           quiet_rx;

    sir_lattice_percolation_engine_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_direction      (i_direction),
        .i_draw           (i_draw),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_infected_count (o_infected_count),
        .o_extinct        (o_extinct),
        .o_rejected       (o_rejected),
        .o_percolates     (o_percolates)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void seed_lattice();
        for (int k = 0; k < CELLS; k++) lattice[k] = SITE_SUS;
        lattice[CENTRE] = SITE_INF;
        live_count = 1;
    endfunction

    function automatic void mark_site(int idx, ref int depth);
        if (!seen[idx] && lattice[idx] == SITE_REC) begin
            seen[idx] = 1'b1;
            fill[depth] = idx;
            depth++;
        end
    endfunction

    function automatic bit recovered_spans();
        int depth = 0;
        int idx, r, c;
        bit hit = 1'b0;
        for (int k = 0; k < CELLS; k++) seen[k] = 1'b0;
        for (int k = 0; k < SIDE; k++) mark_site(k, depth);
        while (depth > 0) begin
            depth--;
            idx = fill[depth];
            r = idx / SIDE;
            c = idx % SIDE;
            if (r == SIDE - 1) hit = 1'b1;
            if (c > 0) mark_site(idx - 1, depth);
            if (c < SIDE - 1) mark_site(idx + 1, depth);
            if (r > 0) mark_site(idx - SIDE, depth);
            if (r < SIDE - 1) mark_site(idx + SIDE, depth);
        end
        return hit;
    endfunction

    function automatic bit apply_event(int r, int c, logic [DIR_W-1:0] d,
                                       logic [DRAW_W-1:0] dr);
        int nr = r;
        int nc = c;
        int act, nb;
        case (d)
            DIR_LEFT: begin
                if (c == 0) return 1'b1;
                nc = c - 1;
            end
            DIR_RIGHT: begin
                if (c == SIDE - 1) return 1'b1;
                nc = c + 1;
            end
            DIR_UP: begin
                if (r == 0) return 1'b1;
                nr = r - 1;
            end
            default: begin
                if (r == SIDE - 1) return 1'b1;
                nr = r + 1;
            end
        endcase
        act = r * SIDE + c;
        nb  = nr * SIDE + nc;
        if (dr > threshold) begin
            if (lattice[act] == SITE_INF && lattice[nb] == SITE_SUS) begin
                lattice[nb] = SITE_INF;
                live_count++;
            end
        end else if (lattice[act] == SITE_INF) begin
            lattice[act] = SITE_REC;
            if (live_count > 0) live_count--;
        end
        return 1'b0;
    endfunction

    function automatic t_outcome predict_outcome(logic [OP_W-1:0] op, int r, int c,
                                                 logic [DIR_W-1:0] d,
                                                 logic [DRAW_W-1:0] dr);
        t_outcome o;
        o.rejected   = 1'b0;
        o.percolates = 1'b0;
        if (op == OP_INIT) seed_lattice();
        else if (op == OP_EVENT) o.rejected = apply_event(r, c, d, dr);
        else if (op == OP_CHECK) o.percolates = recovered_spans();
        o.count   = live_count[CNT_OUT_W-1:0];
        o.extinct = (live_count == 0);
        return o;
    endfunction

    function automatic int gap_length();
        int p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken, or after an idle gap that follows it.
    task automatic send_item(logic [OP_W-1:0] op, logic [5:0] r, logic [5:0] c,
                             logic [DIR_W-1:0] d, logic [DRAW_W-1:0] dr);
        int gap;
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_row       <= r;
        i_col       <= c;
        i_direction <= d;
        i_draw      <= dr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_outcomes.push_back(predict_outcome(op, r, c, d, dr));
        items_sent++;
        if (op == OP_CHECK) checks_sent++;
        gap = no_gaps ? 0 : gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [THR_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        threshold = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Picks an infected site when one exists, starting from a random place.
    task automatic pick_live_site(output logic [5:0] r, output logic [5:0] c);
        int start = $urandom_range(0, CELLS - 1);
        int idx;
        r = 6'($urandom_range(0, SIDE - 1));
        c = 6'($urandom_range(0, SIDE - 1));
        for (int k = 0; k < CELLS; k++) begin
            idx = (start + k) % CELLS;
            if (lattice[idx] == SITE_INF) begin
                r = 6'(idx / SIDE);
                c = 6'(idx % SIDE);
                return;
            end
        end
    endtask

    task automatic test_edges_and_ops();
        no_gaps = 1'b0;
        send_item(OP_CHECK, 0, 0, DIR_LEFT, 0);
        send_item(OP_EVENT, 0, 0, DIR_LEFT, 16'hFFFF);
        send_item(OP_EVENT, 0, 0, DIR_UP, 16'h0000);
        send_item(OP_EVENT, 63, 63, DIR_RIGHT, 16'hFFFF);
        send_item(OP_EVENT, 63, 63, DIR_DOWN, 16'h0000);
        send_item(OP_EVENT, 63, 0, DIR_DOWN, 16'h8000);
        send_item(OP_EVENT, 0, 63, DIR_RIGHT, 16'h7FFF);
        send_item(OP_SPARE, 6'h2A, 6'h15, DIR_DOWN, 16'hAAAA);
        send_item(OP_EVENT, 32, 32, DIR_RIGHT, 16'hFFFF);
        send_item(OP_EVENT, 32, 33, DIR_UP, 16'h5555);
        // A draw equal to the threshold means recovery.
        send_item(OP_EVENT, 32, 32, DIR_LEFT, THR_RESET);
        send_item(OP_EVENT, 32, 33, DIR_DOWN, THR_RESET + 16'd1);
        send_item(OP_CHECK, 0, 0, DIR_LEFT, 0);
        send_item(OP_EVENT, 31, 33, DIR_LEFT, 16'hFFFF);
        send_item(OP_INIT, 6'h3F, 6'h3F, DIR_DOWN, 16'hFFFF);
        send_item(OP_SPARE, 0, 0, DIR_LEFT, 0);
        send_item(OP_EVENT, 32, 32, DIR_UP, 16'h0000);
        send_item(OP_CHECK, 6'h3F, 6'h3F, DIR_DOWN, 16'hFFFF);
        send_item(OP_INIT, 0, 0, DIR_LEFT, 0);
    endtask

    task automatic test_threshold_extremes();
        set_threshold(16'd0);
        send_item(OP_EVENT, 32, 32, DIR_DOWN, 16'd1);
        send_item(OP_EVENT, 32, 32, DIR_UP, 16'd0);
        set_threshold(16'hFFFF);
        send_item(OP_EVENT, 33, 32, DIR_DOWN, 16'hFFFF);
        send_item(OP_INIT, 0, 0, DIR_LEFT, 0);
    endtask

    // Grows an infected column through the whole lattice, recovers it, then checks.
    task automatic test_spanning_column();
        set_threshold(16'd0);
        send_item(OP_INIT, 0, 0, DIR_LEFT, 0);
        for (int r = SIDE / 2; r > 0; r--)
            send_item(OP_EVENT, 6'(r), 6'(SIDE / 2), DIR_UP, 16'($urandom_range(1, 65535)));
        for (int r = SIDE / 2; r < SIDE - 1; r++)
            send_item(OP_EVENT, 6'(r), 6'(SIDE / 2), DIR_DOWN, 16'($urandom_range(1, 65535)));
        set_threshold(16'hFFFF);
        for (int r = 0; r < SIDE; r++)
            send_item(OP_EVENT, 6'(r), 6'(SIDE / 2), DIR_LEFT, 16'($urandom_range(0, 65535)));
        send_item(OP_CHECK, 0, 0, DIR_LEFT, 0);
        send_item(OP_CHECK, 0, 0, DIR_LEFT, 0);
        set_threshold(THR_RESET);
    endtask

    task automatic test_backpressure();
        drain();
        no_gaps = 1'b1;
        hold_asked++;
        for (int k = 0; k < 40; k++) send_item(OP_SPARE, 6'(k), 6'(k), k[1:0], 16'(k));
        no_gaps = 1'b0;
        drain();
    endtask

    task automatic test_random_epidemics();
        logic [5:0]  r, c;
        logic [15:0] dr;
        int p, sent, phase_len;
        sent = 0;
        while (sent < N_RANDOM) begin
            p = $urandom_range(0, 9);
            if (p == 0) set_threshold(16'd0);
            else if (p == 1) set_threshold(16'hFFFF);
            else set_threshold(16'($urandom_range(0, 65535)));
            no_gaps  = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(30, 90);
            for (int k = 0; k < phase_len; k++) begin
                p = $urandom_range(0, 199);
                dr = 16'($urandom_range(0, 65535));
                if (p < 4) begin
                    send_item(OP_CHECK, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                              2'($urandom_range(0, 3)), dr);
                end else if (p < 8 || (live_count == 0 && p < 60)) begin
                    send_item(OP_INIT, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                              2'($urandom_range(0, 3)), dr);
                end else if (p < 12) begin
                    send_item(OP_SPARE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                              2'($urandom_range(0, 3)), dr);
                end else if (p < 40) begin
                    send_item(OP_EVENT, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                              2'($urandom_range(0, 3)), dr);
                end else begin
                    pick_live_site(r, c);
                    send_item(OP_EVENT, r, c, 2'($urandom_range(0, 3)), dr);
                end
                sent++;
            end
        end
        no_gaps  = 1'b0;
        quiet_rx = 1'b0;
    endtask

    // Result side stalls at random, with occasional long hold-offs, a long hold on request and none when quiet.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_asked != hold_served) begin
            i_out_stall <= 1'b1;
            hold_left   <= 400;
            hold_served <= hold_asked;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (quiet_rx) begin
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 299) == 0) begin
            i_out_stall <= 1'b1;
            hold_left <= $urandom_range(20, 60);
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_infected_count !== want.count || o_extinct !== want.extinct ||
                    o_rejected !== want.rejected || o_percolates !== want.percolates) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch cycle %0d: exp cnt=%0d ext=%0b rej=%0b perc=%0b, got cnt=%0d ext=%0b rej=%0b perc=%0b",
                                 cycles, want.count, want.extinct, want.rejected,
                                 want.percolates, o_infected_count, o_extinct,
                                 o_rejected, o_percolates);
                end else if (want.percolates) begin
                    spans_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        items_sent  = 0;
        checks_sent = 0;
        no_gaps     = 1'b0;
        quiet_rx    = 1'b0;
        threshold   = THR_RESET;
        seed_lattice();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_op        = OP_INIT;
        i_row       = '0;
        i_col       = '0;
        i_direction = DIR_LEFT;
        i_draw      = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edges_and_ops();
        test_threshold_extremes();
        test_spanning_column();
        test_backpressure();
        test_random_epidemics();

        drain();
        repeat (50) @(posedge i_clk);
        if (pending_outcomes.size() != 0)
            $display("%0d expected results never arrived", pending_outcomes.size());
        $display("covered %0d requests, %0d spanning checks (%0d spanning), all thresholds",
                 items_sent, checks_sent, spans_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/slpe_pkg.sv
rtl/core/slpe_lattice_ram.sv
rtl/core/sir_lattice_percolation_engine_unit.sv
tb/sv/tb.sv
